>>> src/csfc_pkg.sv
// Shared widths, constants, types and helpers of the crop and scale fit calculator.
// Used by the core and by its port checker; depends on nothing else.
package csfc_pkg;

    // Field widths.
    localparam int DIM_W   = 13;
    localparam int OFS_W   = 11;
    localparam int SCALE_W = 21;

    // Largest usable frame or panel dimension; larger values saturate to it.
    localparam int MAX_DIM = 4096;

    // Scale resolution: 1/256 steps, i.e. 8 fraction bits.
    localparam int SCALE_STEPS = 256;
    localparam int SCALE_SHIFT = $clog2(SCALE_STEPS);

    // Product of two saturated dimensions, also the dividend width of the divider.
    localparam int PROD_W = 2 * $clog2(MAX_DIM) + 1;

    // Dividend bits used by the scale search: panel size shifted by the fraction bits.
    localparam int FIT_STEPS = DIM_W + SCALE_SHIFT;

    // Step counter, wide enough for a full-width division.
    localparam int CNT_W = $clog2(PROD_W + 1);

    // Configuration port.
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_BIT = 2;

    // Register indexes.
    localparam logic REG_DISPLAY_WIDTH  = 1'b0;
    localparam logic REG_DISPLAY_HEIGHT = 1'b1;

    // Reset values of the panel size registers.
    localparam int DISPLAY_WIDTH_RST  = 1024;
    localparam int DISPLAY_HEIGHT_RST = 600;

    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [OFS_W-1:0]   t_ofs;
    typedef logic [SCALE_W-1:0] t_scale;
    typedef logic [PROD_W-1:0]  t_prod;

    // Saturate a dimension to the largest supported size.
    function automatic t_dim clamp_dim(input t_dim v);
        return (v > t_dim'(MAX_DIM)) ? t_dim'(MAX_DIM) : v;
    endfunction

endpackage

>>> src/crop_scale_fit_calculator_core.sv
// Top level of the crop and scale fit calculator: one sequencer with a bit-serial
// multiplier and a shared bit-serial divider. Depends on csfc_pkg.
//
// Usage. A beat on the input channel (i_in_valid / o_in_ready) carries one camera
// frame size. For it the block returns one beat on the output channel
// (o_out_valid / i_out_ready) with a centered crop window, its offsets and the two
// scale factors (8 fraction bits) that map the crop exactly onto the panel size
// held in the two configuration registers, written over the APB-style port.
// Sequencing. One frame size is handled at a time; o_in_ready is high only
// while the sequencer is idle. A repeat of the cached frame size goes straight
// to handing over the result. Any other size runs a shift-add multiplication
// (one multiplier bit per cycle), the crop division (one quotient bit per cycle)
// and the crop setting, then, for every crop size tried by the scale search of
// each axis, a divider load, the divider steps and a fit check, and finally the
// handover of the result; an axis whose crop is zero skips its search. The search
// count depends on the data: one attempt per axis in the common case, up
// to a few thousand when the frame is much larger than the panel.
// Reset loads the panel size 1024 x 600, empties the result cache and leaves the
// output channel empty. When the receiver stalls, a finished result waits in the
// output register; a new frame size is still accepted, and its result waits for
// the output register to drain.
module crop_scale_fit_calculator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  csfc_pkg::t_dim                   i_in_width,
    input  csfc_pkg::t_dim                   i_in_height,
    // Output channel.
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output csfc_pkg::t_dim                   o_crop_w,
    output csfc_pkg::t_dim                   o_crop_h,
    output csfc_pkg::t_ofs                   o_offset_x,
    output csfc_pkg::t_ofs                   o_offset_y,
    output csfc_pkg::t_scale                 o_scale_x_fixed,
    output csfc_pkg::t_scale                 o_scale_y_fixed,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [csfc_pkg::APB_AW-1:0]      paddr,
    input  logic [csfc_pkg::APB_DW-1:0]      pwdata,
    output logic [csfc_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import csfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CROP_DIV,
        S_CROP_SET,
        S_FIT_LOAD,
        S_FIT_DIV,
        S_FIT_CHECK,
        S_DONE
    } t_state;

    t_state           r_state;

    // Configuration registers, stored as written (13 bits) and saturated at use.
    t_dim             r_disp_w;
    t_dim             r_disp_h;

    // Result cache. A cached width of zero means the cache is empty. The crop and
    // scale registers double as the working registers of a new calculation.
    t_dim             r_last_w;
    t_dim             r_last_h;
    t_dim             r_crop_w;
    t_dim             r_crop_h;
    t_scale           r_scale_x;
    t_scale           r_scale_y;

    // Saturated frame size of the current beat.
    t_dim             r_w;
    t_dim             r_h;

    // Shift-add multiplier: two products formed side by side.
    t_prod            r_acc_a;      // width times panel height
    t_prod            r_acc_b;      // height times panel width
    t_prod            r_mcand_w;
    t_prod            r_mcand_h;
    t_dim             r_mplr_a;
    t_dim             r_mplr_b;

    // Restoring divider: dividend shifts out of r_dq as quotient bits shift in.
    t_prod            r_dq;
    logic [DIM_W:0]   r_rem;
    t_dim             r_div;
    logic [CNT_W-1:0] r_cnt;

    // Scale search.
    t_dim             r_s;          // crop size under test
    logic             r_axis;       // 0: horizontal, 1: vertical
    logic             r_narrow_w;   // the crop division narrows the width

    // Output register.
    logic             r_out_valid;
    t_dim             r_out_crop_w;
    t_dim             r_out_crop_h;
    t_ofs             r_out_ofs_x;
    t_ofs             r_out_ofs_y;
    t_scale           r_out_scale_x;
    t_scale           r_out_scale_y;

    // Combinational helpers.
    t_dim             in_w_cl;
    t_dim             in_h_cl;
    t_dim             disp_w_cl;
    t_dim             disp_h_cl;
    logic             cache_hit;
    logic             cfg_write;
    logic             cfg_idx;
    t_prod            n_acc_a;
    t_prod            n_acc_b;
    logic [DIM_W:0]   rem_shift;
    logic             q_bit;
    logic [DIM_W:0]   n_rem;
    t_prod            n_dq;
    t_dim             crop_q;
    t_dim             fit_out;
    t_dim             fit_rem;
    t_dim             fit_gap;
    logic             fit_hit;
    t_scale           fit_scale;
    t_dim             diff_x;
    t_dim             diff_y;
    t_ofs             ofs_x;
    t_ofs             ofs_y;

    assign in_w_cl   = clamp_dim(i_in_width);
    assign in_h_cl   = clamp_dim(i_in_height);
    assign disp_w_cl = clamp_dim(r_disp_w);
    assign disp_h_cl = clamp_dim(r_disp_h);

    // A zero width never matches, so an empty cache cannot hit.
    assign cache_hit = (i_in_width != '0) && (r_last_w == i_in_width)
                       && (r_last_h == i_in_height);

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[REG_IDX_BIT];

    // One multiplier bit per cycle for each of the two products.
    assign n_acc_a = r_acc_a + (r_mplr_a[0] ? r_mcand_w : '0);
    assign n_acc_b = r_acc_b + (r_mplr_b[0] ? r_mcand_h : '0);

    // One quotient bit per cycle.
    assign rem_shift = {r_rem[DIM_W-1:0], r_dq[PROD_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, r_div});
    assign n_rem     = q_bit ? (rem_shift - {1'b0, r_div}) : rem_shift;
    assign n_dq      = {r_dq[PROD_W-2:0], q_bit};

    // Division by a zero panel dimension gives zero.
    assign crop_q = (r_div == '0) ? '0 : r_dq[DIM_W-1:0];

    // With c = ceil(N / s) and N = panel size times SCALE_STEPS, the product s * c
    // equals N + (s - rem) when the remainder is nonzero. The floored scaled size
    // hits the panel size exactly when the remainder is zero or s - rem stays
    // below one scale step, so no multiplication is needed for the check.
    assign fit_out   = r_axis ? disp_h_cl : disp_w_cl;
    assign fit_rem   = r_rem[DIM_W-1:0];
    assign fit_gap   = r_s - fit_rem;
    assign fit_hit   = (fit_rem == '0) || (fit_gap < t_dim'(SCALE_STEPS));
    assign fit_scale = r_dq[SCALE_W-1:0] + SCALE_W'(fit_rem != '0);

    // Centered offsets, halved and kept to the field width.
    assign diff_x = r_w - r_crop_w;
    assign diff_y = r_h - r_crop_h;
    assign ofs_x  = (r_w >= r_crop_w) ? diff_x[OFS_W:1] : '0;
    assign ofs_y  = (r_h >= r_crop_h) ? diff_y[OFS_W:1] : '0;

    assign o_in_ready = (r_state == S_IDLE);

    assign o_out_valid     = r_out_valid;
    assign o_crop_w        = r_out_crop_w;
    assign o_crop_h        = r_out_crop_h;
    assign o_offset_x      = r_out_ofs_x;
    assign o_offset_y      = r_out_ofs_y;
    assign o_scale_x_fixed = r_out_scale_x;
    assign o_scale_y_fixed = r_out_scale_y;

    assign pready = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_DISPLAY_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, r_disp_w};
            REG_DISPLAY_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, r_disp_h};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_disp_w    <= t_dim'(DISPLAY_WIDTH_RST);
            r_disp_h    <= t_dim'(DISPLAY_HEIGHT_RST);
            r_last_w    <= '0;
            r_last_h    <= '0;
            r_crop_w    <= '0;
            r_crop_h    <= '0;
            r_scale_x   <= '0;
            r_scale_y   <= '0;
        end else begin
            // In S_DONE the output register is refilled by the state machine instead.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_w <= in_w_cl;
                        r_h <= in_h_cl;
                        if (cache_hit) begin
                            r_state <= S_DONE;
                        end else begin
                            r_last_w  <= i_in_width;
                            r_last_h  <= i_in_height;
                            r_crop_w  <= in_w_cl;
                            r_crop_h  <= in_h_cl;
                            r_scale_x <= '0;
                            r_scale_y <= '0;
                            r_acc_a   <= '0;
                            r_acc_b   <= '0;
                            r_mcand_w <= PROD_W'(in_w_cl);
                            r_mcand_h <= PROD_W'(in_h_cl);
                            r_mplr_a  <= disp_h_cl;
                            r_mplr_b  <= disp_w_cl;
                            r_cnt     <= CNT_W'(DIM_W);
                            r_state   <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    r_acc_a   <= n_acc_a;
                    r_acc_b   <= n_acc_b;
                    r_mcand_w <= r_mcand_w << 1;
                    r_mcand_h <= r_mcand_h << 1;
                    r_mplr_a  <= r_mplr_a >> 1;
                    r_mplr_b  <= r_mplr_b >> 1;
                    r_cnt     <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        // The frame is relatively wider than the panel: narrow the
                        // width to height * panel_w / panel_h, else the height.
                        if (n_acc_a > n_acc_b) begin
                            r_narrow_w <= 1'b1;
                            r_dq       <= n_acc_b;
                            r_div      <= disp_h_cl;
                        end else begin
                            r_narrow_w <= 1'b0;
                            r_dq       <= n_acc_a;
                            r_div      <= disp_w_cl;
                        end
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(PROD_W);
                        r_state <= S_CROP_DIV;
                    end
                end

                S_CROP_DIV: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_CROP_SET;
                    end
                end

                S_CROP_SET: begin
                    if (r_narrow_w) begin
                        r_crop_w <= crop_q;
                        r_s      <= crop_q;
                    end else begin
                        r_crop_h <= crop_q;
                        r_s      <= r_crop_w;
                    end
                    r_axis  <= 1'b0;
                    r_state <= S_FIT_LOAD;
                end

                S_FIT_LOAD: begin
                    if (r_s == '0) begin
                        // Nothing left to search: this axis gets crop 0 and scale 0.
                        if (!r_axis) begin
                            r_crop_w <= '0;
                            r_scale_x <= '0;
                            r_s      <= r_crop_h;
                            r_axis   <= 1'b1;
                        end else begin
                            r_crop_h  <= '0;
                            r_scale_y <= '0;
                            r_state   <= S_DONE;
                        end
                    end else begin
                        // Dividend is the panel size times SCALE_STEPS, left-aligned.
                        r_dq    <= {fit_out, {(PROD_W-DIM_W){1'b0}}};
                        r_rem   <= '0;
                        r_div   <= r_s;
                        r_cnt   <= CNT_W'(FIT_STEPS);
                        r_state <= S_FIT_DIV;
                    end
                end

                S_FIT_DIV: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIT_CHECK;
                    end
                end

                S_FIT_CHECK: begin
                    if (fit_hit) begin
                        if (!r_axis) begin
                            r_crop_w  <= r_s;
                            r_scale_x <= fit_scale;
                            r_s       <= r_crop_h;
                            r_axis    <= 1'b1;
                            r_state   <= S_FIT_LOAD;
                        end else begin
                            r_crop_h  <= r_s;
                            r_scale_y <= fit_scale;
                            r_state   <= S_DONE;
                        end
                    end else begin
                        r_s     <= r_s - t_dim'(1);
                        r_state <= S_FIT_LOAD;
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_crop_w  <= r_crop_w;
                        r_out_crop_h  <= r_crop_h;
                        r_out_ofs_x   <= ofs_x;
                        r_out_ofs_y   <= ofs_y;
                        r_out_scale_x <= r_scale_x;
                        r_out_scale_y <= r_scale_y;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A new panel size invalidates every cached result.
            if (cfg_write) begin
                unique case (cfg_idx)
                    REG_DISPLAY_WIDTH:  r_disp_w <= pwdata[DIM_W-1:0];
                    REG_DISPLAY_HEIGHT: r_disp_h <= pwdata[DIM_W-1:0];
                    default:            r_disp_w <= r_disp_w;
                endcase
                r_last_w  <= '0;
                r_last_h  <= '0;
                r_crop_w  <= '0;
                r_crop_h  <= '0;
                r_scale_x <= '0;
                r_scale_y <= '0;
            end
        end
    end

endmodule

>>> src/csfc_checker.sv
// Port-level checker for the crop and scale fit calculator, bound to its top level.
// Depends on csfc_pkg and on crop_scale_fit_calculator_core.
module csfc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input csfc_pkg::t_dim                   o_crop_w,
    input csfc_pkg::t_dim                   o_crop_h,
    input csfc_pkg::t_ofs                   o_offset_x,
    input csfc_pkg::t_ofs                   o_offset_y,
    input csfc_pkg::t_scale                 o_scale_x_fixed,
    input csfc_pkg::t_scale                 o_scale_y_fixed,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [csfc_pkg::APB_AW-1:0]      paddr,
    input logic [csfc_pkg::APB_DW-1:0]      pwdata,
    input logic [csfc_pkg::APB_DW-1:0]      prdata,
    input logic                             pready
);
    import csfc_pkg::*;

    logic in_beat;
    logic width_write;

    assign in_beat     = i_in_valid && o_in_ready;
    assign width_write = psel && penable && pwrite && pready && !paddr[REG_IDX_BIT];

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_crop_w)
            && $stable(o_crop_h) && $stable(o_offset_x) && $stable(o_offset_y)
            && $stable(o_scale_x_fixed) && $stable(o_scale_y_fixed)))
        else $error("result beat changed while stalled");

    // The block works on one frame size at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // A result appears only after a calculation held the input side busy.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a calculation");

    // A zero crop always comes with a zero scale.
    a_zero_crop_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_crop_w != '0 || o_scale_x_fixed == '0)
            && (o_crop_h != '0 || o_scale_y_fixed == '0)))
        else $error("nonzero scale for an empty crop");

    // A written panel width reads back at once.
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(width_write) && $past(i_rst_n) && psel && !pwrite && !paddr[REG_IDX_BIT])
            |-> (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0])))
        else $error("panel width read back wrong");

endmodule

bind crop_scale_fit_calculator_core csfc_checker u_csfc_checker (.*);
